FILE: design/cndl_pkg.sv
// ----------------------------------------------------------------------------
// cndl_pkg - shared types and constants for the circular next date lookup
// Item structs, table entry layout, status codes and the day of year helper.
// ----------------------------------------------------------------------------
package cndl_pkg;

  // table sizing
  localparam int MAX_ENTRIES = 64;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DAY_W       = 9;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_BAD_MONTH = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic [3:0] month;
    logic [4:0] day;
    logic [7:0] member_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       found_id;
    logic [DAY_W-1:0] found_day;
  } out_item_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [ID_BITS-1:0] id;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  // month 1..12 is valid
  function automatic logic month_ok(input logic [3:0] m);
    return (m >= 4'd1) && (m <= 4'd12);
  endfunction

  // non-leap month prefix plus day of month
  function automatic logic [DAY_W-1:0] day_of_year(input logic [3:0] m,
                                                   input logic [4:0] d);
    logic [DAY_W-1:0] base;
    unique case (m)
      4'd1:    base = DAY_W'(0);
      4'd2:    base = DAY_W'(31);
      4'd3:    base = DAY_W'(59);
      4'd4:    base = DAY_W'(90);
      4'd5:    base = DAY_W'(120);
      4'd6:    base = DAY_W'(151);
      4'd7:    base = DAY_W'(181);
      4'd8:    base = DAY_W'(212);
      4'd9:    base = DAY_W'(243);
      4'd10:   base = DAY_W'(273);
      4'd11:   base = DAY_W'(304);
      4'd12:   base = DAY_W'(334);
      default: base = '0;
    endcase
    return base + DAY_W'(d);
  endfunction

  // stored entry orders after the new key (day first, then smaller id)
  function automatic logic entry_after(input entry_t e, input entry_t k);
    return (e.day > k.day) || ((e.day == k.day) && (e.id > k.id));
  endfunction

endpackage

FILE: design/cndl_store.sv
// ----------------------------------------------------------------------------
// cndl_store - entry table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cndl_store
  import cndl_pkg::*;
(
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_q
);

  entry_t mem [MAX_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

endmodule

FILE: design/circular_next_date_lookup.sv
// ----------------------------------------------------------------------------
// circular_next_date_lookup - sorted dated table with circular successor query
// Keeps entries sorted by day of year and id; inserts and next-date queries.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_item while busy is low; the item is taken at that edge.
//   An insert (req_type 0) places (date, member_id) in sorted order; a query
//   (req_type 1) returns the first entry on or after the date, wrapping to
//   the earliest entry. Each item gives exactly one result, shown on out_item
//   for one cycle with out_valid high; the receiver cannot stall it.
//   Bad month, full table, empty table and insert into an empty table answer
//   in the cycle after the item is taken. An insert otherwise scans the
//   table backward from the last entry, shifting one entry per cycle; a
//   query scans forward one entry per cycle. The single read port of the
//   entry memory sets the pace.
//   busy is high while a scan runs; the next item may be taken in the cycle
//   the result is shown.
//   Reset empties the table (count to zero); memory contents are not cleared.
// ----------------------------------------------------------------------------
module circular_next_date_lookup
  import cndl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;
  localparam logic [1:0] S_QRY  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  entry_t           key_r, key_nxt;
  entry_t           first_r, first_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             accept;
  logic             mok;
  entry_t           new_key;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_q;
  mem_wr_t          wr;
  logic [CNT_W-1:0] last_idx;

  assign accept   = start && (state_r == S_IDLE);
  assign mok      = month_ok(in_item.month);
  assign new_key  = '{day: day_of_year(in_item.month, in_item.day),
                      id:  ID_BITS'(in_item.member_id)};
  assign last_idx = CNT_W'(count_r - 1'b1);

  cndl_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_q    (rd_q)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr            = '0;
    rd_addr       = idx_r;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = (in_item.req_type == REQ_QUERY) ? '0 : IDX_W'(last_idx);
        if (accept) begin
          out_item_nxt = '{status: ST_INSERTED, found_id: '0, found_day: '0};
          key_nxt      = new_key;
          if (in_item.req_type == REQ_INSERT) begin
            if (!mok) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_BAD_MONTH;
            end else if (count_r >= CNT_W'(MAX_ENTRIES)) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_FULL;
            end else if (count_r == '0) begin
              wr            = '{en: 1'b1, addr: '0, data: new_key};
              count_nxt     = count_r + 1'b1;
              out_valid_nxt = 1'b1;
            end else begin
              idx_nxt   = IDX_W'(last_idx);
              state_nxt = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_EMPTY;
            end else if (!mok) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_BAD_MONTH;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_QRY;
            end
          end
        end
      end
      // backward scan: shift larger entries up one slot
      S_INS: begin
        rd_addr = idx_r - 1'b1;
        if (entry_after(rd_q, key_r)) begin
          wr = '{en: 1'b1, addr: idx_r + 1'b1, data: rd_q};
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          wr            = '{en: 1'b1, addr: idx_r + 1'b1, data: key_r};
          count_nxt     = count_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_INSERTED, found_id: '0, found_day: '0};
          state_nxt     = S_IDLE;
        end
      end
      // new key goes to the head
      S_PUT: begin
        wr            = '{en: 1'b1, addr: '0, data: key_r};
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_INSERTED, found_id: '0, found_day: '0};
        state_nxt     = S_IDLE;
      end
      // forward scan for first day on or after the key
      S_QRY: begin
        rd_addr = idx_r + 1'b1;
        if (idx_r == '0) begin
          first_nxt = rd_q;
        end
        if (rd_q.day >= key_r.day) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_FOUND, found_id: 8'(rd_q.id),
                            found_day: rd_q.day};
          state_nxt     = S_IDLE;
        end else if (CNT_W'(idx_r) == last_idx) begin
          // no later entry: wrap to the earliest
          out_valid_nxt = 1'b1;
          if (idx_r == '0) begin
            out_item_nxt = '{status: ST_FOUND, found_id: 8'(rd_q.id),
                             found_day: rd_q.day};
          end else begin
            out_item_nxt = '{status: ST_FOUND, found_id: 8'(first_r.id),
                             found_day: first_r.day};
          end
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    first_r    <= first_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a result is only shown once the scan is over
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result shown while a scan is running");

  // table never overfills
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count past table depth");

  // a completed insert grows the table by exactly one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status == ST_INSERTED)) |->
      (count_r == $past(count_r) + 1'b1))
    else $error("insert result without count update");

  // scan index stays inside the filled part
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_INS) || (state_r == S_QRY)) |-> (CNT_W'(idx_r) < count_r))
    else $error("scan index beyond filled entries");

  // count changes only with a result
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> ($past(count_r) == count_r) || out_valid_r)
    else $error("count changed without a result");

endmodule

FILE: tb/cndl_checker.sv
// ----------------------------------------------------------------------------
// cndl_checker - result checker for the circular next date lookup
// Watches the item and result channels, keeps its own copy of the sorted
// table, works out the result of every accepted item and compares it field
// by field with the result the block shows.
// ----------------------------------------------------------------------------
module cndl_checker
  import cndl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  // shadow table, sorted by day of year then id
  logic [DAY_W-1:0]   tbl_day [MAX_ENTRIES];
  logic [ID_BITS-1:0] tbl_id  [MAX_ENTRIES];
  int                 tbl_count;

  // results owed by the block, oldest first
  out_item_t due_q [$];

  // month 1..12 is a real month
  function automatic bit real_month(input logic [3:0] m);
    return (m != 4'd0) && (m <= 4'd12);
  endfunction

  // non-leap day of year; day of month added unchecked
  function automatic logic [DAY_W-1:0] doy_of(input logic [3:0] m, input logic [4:0] d);
    int prefix;
    case (m)
      4'd2:    prefix = 31;
      4'd3:    prefix = 59;
      4'd4:    prefix = 90;
      4'd5:    prefix = 120;
      4'd6:    prefix = 151;
      4'd7:    prefix = 181;
      4'd8:    prefix = 212;
      4'd9:    prefix = 243;
      4'd10:   prefix = 273;
      4'd11:   prefix = 304;
      4'd12:   prefix = 334;
      default: prefix = 0;
    endcase
    return DAY_W'(prefix + int'(d));
  endfunction

  // apply one item to the shadow table and return its result
  function automatic out_item_t next_date_result(input in_item_t it);
    out_item_t        r;
    logic [DAY_W-1:0] doy;
    int               pos;
    int               i;
    r   = '0;
    doy = doy_of(it.month, it.day);
    pos = 0;
    if (it.req_type == REQ_INSERT) begin
      if (!real_month(it.month)) begin
        r.status = ST_BAD_MONTH;
      end else if (tbl_count >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        // equal keys go after the stored ones
        while (pos < tbl_count && (tbl_day[pos] < doy ||
               (tbl_day[pos] == doy && tbl_id[pos] <= it.member_id[ID_BITS-1:0])))
          pos++;
        for (i = tbl_count; i > pos; i--) begin
          tbl_day[i] = tbl_day[i-1];
          tbl_id[i]  = tbl_id[i-1];
        end
        tbl_day[pos] = doy;
        tbl_id[pos]  = it.member_id[ID_BITS-1:0];
        tbl_count++;
        r.status = ST_INSERTED;
      end
    end else begin
      // empty table wins over a bad month
      if (tbl_count == 0) begin
        r.status = ST_EMPTY;
      end else if (!real_month(it.month)) begin
        r.status = ST_BAD_MONTH;
      end else begin
        while (pos < tbl_count && tbl_day[pos] < doy)
          pos++;
        // nothing on or after the date: wrap to the earliest entry
        if (pos >= tbl_count)
          pos = 0;
        r.status    = ST_FOUND;
        r.found_id  = 8'(tbl_id[pos]);
        r.found_day = tbl_day[pos];
      end
    end
    return r;
  endfunction

  // compare results, then record the item taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t owed;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      tbl_count = 0;
      due_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (due_q.size() == 0) begin
          $display("%0t: result with no item outstanding: status %0d id %0d day %0d",
                   $time, out_item.status, out_item.found_id, out_item.found_day);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_item.status);
            errs++;
          end
          if (out_item.found_id !== want.found_id) begin
            $display("%0t: found_id mismatch: expected %0d, actual %0d",
                     $time, want.found_id, out_item.found_id);
            errs++;
          end
          if (out_item.found_day !== want.found_day) begin
            $display("%0t: found_day mismatch: expected %0d, actual %0d",
                     $time, want.found_day, out_item.found_day);
            errs++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        owed  = next_date_result(in_item);
        due_q = {due_q, owed};
      end
      fail_count <= fail_count + errs;
      pending    <= due_q.size();
    end
  end

endmodule

FILE: tb/circular_next_date_lookup_tb.sv
// ----------------------------------------------------------------------------
// circular_next_date_lookup_tb - testbench top for the next date lookup
// Drives directed items (empty table, bad months, odd days, ties, wrap) and
// then random bursts of inserts and queries that fill the table past full;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module circular_next_date_lookup_tb;
  import cndl_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycles = 0;

  circular_next_date_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  cndl_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t mk(input logic rq, input int m, input int d, input int id);
    in_item_t it;
    it.req_type  = rq;
    it.month     = 4'(m);
    it.day       = 5'(d);
    it.member_id = 8'(id);
    return it;
  endfunction

  // hold the item until the block takes it
  task automatic send_item(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // stop sending until every result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // stimulus and verdict
  initial begin
    in_item_t seq [$];
    in_item_t it;
    int       sent;
    int       burst;
    int       gap;
    int       k;
    int       pick;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, also for a bad month
    seq = {seq, mk(REQ_QUERY, 1, 1, 0)};
    seq = {seq, mk(REQ_QUERY, 0, 5, 9)};
    // bad months store nothing
    seq = {seq, mk(REQ_INSERT, 0, 1, 1)};
    seq = {seq, mk(REQ_INSERT, 13, 2, 2)};
    seq = {seq, mk(REQ_INSERT, 15, 31, 255)};
    seq = {seq, mk(REQ_QUERY, 15, 0, 0)};
    // day 0, odd day past month end, equal keys and smaller id first
    seq = {seq, mk(REQ_INSERT, 1, 0, 255)};
    seq = {seq, mk(REQ_INSERT, 2, 31, 7)};
    seq = {seq, mk(REQ_INSERT, 3, 3, 7)};
    seq = {seq, mk(REQ_INSERT, 3, 3, 3)};
    seq = {seq, mk(REQ_INSERT, 3, 3, 7)};
    seq = {seq, mk(REQ_INSERT, 6, 15, 128)};
    // wrap past the last entry
    seq = {seq, mk(REQ_QUERY, 12, 31, 0)};
    seq = {seq, mk(REQ_QUERY, 6, 16, 255)};
    // exact hits and lookups between entries
    seq = {seq, mk(REQ_QUERY, 1, 0, 0)};
    seq = {seq, mk(REQ_QUERY, 3, 3, 255)};
    seq = {seq, mk(REQ_QUERY, 1, 1, 0)};
    seq = {seq, mk(REQ_INSERT, 12, 31, 0)};
    seq = {seq, mk(REQ_QUERY, 12, 31, 31)};
    seq = {seq, mk(REQ_QUERY, 11, 30, 0)};
    // bad month on a filled table
    seq = {seq, mk(REQ_QUERY, 13, 1, 0)};
    seq = {seq, mk(REQ_QUERY, 0, 31, 0)};
    foreach (seq[i])
      send_item(seq[i]);
    wait_drained();

    // random bursts; the table fills and then reports full
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        it.req_type = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        // mostly real months, some bad ones
        if (pick < 88)
          it.month = 4'($urandom_range(1, 12));
        else
          it.month = 4'($urandom_range(0, 15));
        it.day = 5'($urandom_range(0, 31));
        // crowd a few dates so ties appear
        if ($urandom_range(0, 3) == 0) begin
          it.month = 4'($urandom_range(3, 4));
          it.day   = 5'($urandom_range(1, 2));
        end
        if ($urandom_range(0, 1) == 0)
          it.member_id = 8'($urandom_range(0, 3));
        else
          it.member_id = 8'($urandom_range(0, 255));
        send_item(it);
        sent++;
        if (sent == RANDOM_ITEMS / 2)
          wait_drained();
      end
      // idle gap with junk on the item bus
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        start   <= 1'b0;
        in_item <= in_item_t'($urandom);
        repeat (gap) @(posedge clk);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
design/cndl_pkg.sv
design/cndl_store.sv
design/circular_next_date_lookup.sv
tb/cndl_checker.sv
tb/circular_next_date_lookup_tb.sv
